[design/pfl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfl_pkg
// Types and codes shared by the per-CPU page free list allocator.
// ----------------------------------------------------------------------------
package pfl_pkg;

  localparam int ADDR_W   = 32;
  localparam int CPU_W    = 3;
  localparam int STATUS_W = 2;
  localparam int ALU_W    = 33;
  localparam int CFG_IDX_W = 1;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_ADDR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_ADDR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE,
    ST_CHK_LO,
    ST_CHK_HI,
    ST_CHK_BASE,
    ST_PUSH,
    ST_PICK,
    ST_LINK,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_op_t;

endpackage

[design/pfl_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfl_if
// Request and response channels of the page free list allocator.
// ----------------------------------------------------------------------------
interface pfl_req_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [pfl_pkg::CPU_W-1:0]    cpu;
  logic [pfl_pkg::ADDR_W-1:0]   address;

  modport source (output valid, output kind, output cpu, output address, input ready);
  modport sink   (input valid, input kind, input cpu, input address, output ready);
endinterface

interface pfl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pfl_pkg::ADDR_W-1:0]    page_addr;
  logic [pfl_pkg::STATUS_W-1:0]  status;
  logic [pfl_pkg::CPU_W-1:0]     served_from;

  modport source (output valid, output page_addr, output status, output served_from,
                  input ready);
  modport sink   (input valid, input page_addr, input status, input served_from,
                  output ready);
endinterface

[design/pfl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/pfl_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfl_alu
// Shared add/subtract unit; bit 33 of a subtract is the borrow (a < b).
// ----------------------------------------------------------------------------
module pfl_alu (
  input  pfl_pkg::alu_op_t          op_i,
  output logic [pfl_pkg::ALU_W:0]   res_o
);

  logic [pfl_pkg::ALU_W:0] a_ext;
  logic [pfl_pkg::ALU_W:0] b_ext;

  assign a_ext = {1'b0, op_i.a};
  assign b_ext = {1'b0, op_i.b} ^ {(pfl_pkg::ALU_W + 1){op_i.sub}};
  assign res_o = a_ext + b_ext + {{pfl_pkg::ALU_W{1'b0}}, op_i.sub};

endmodule

[design/per_cpu_page_free_list_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator
// Page allocator with one LIFO free list per CPU and stealing from other CPUs.
// ----------------------------------------------------------------------------
// One request is handled at a time by a sequencer that steps one shared
// 33-bit add/subtract unit. A free steps through page base, three range
// compares and push; an alloc steps through page base, list pick with link
// memory read and address rebuild, and skips the rebuild when every list is
// empty. The result beat sits in an output register, so the next
// request is accepted in the cycle after the result is handed over, even if
// the response side stalls. The link memory holds no reset state and needs
// no clearing pass.
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_allocator #(
  parameter int CPUS       = 8,
  parameter int PAGES      = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pfl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pfl_pkg::ADDR_W-1:0]        cfg_wdata_i,
  pfl_req_if.sink                           req_i,
  pfl_rsp_if.source                         rsp_o
);

  localparam int SHIFT   = $clog2(PAGE_BYTES);
  localparam int FW      = $clog2(PAGES);
  localparam int CW      = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int FFULL_W = pfl_pkg::ADDR_W - SHIFT;
  localparam logic [pfl_pkg::ALU_W-1:0] OFS_MASK = pfl_pkg::ALU_W'(PAGE_BYTES - 1);

  pfl_pkg::state_e state_q, state_d;

  logic [pfl_pkg::ADDR_W-1:0]   low_q, high_q;
  logic [FW-1:0]                head_q [CPUS];
  logic [31:0]                  cnt_q  [CPUS];

  logic                         kind_q;
  logic [pfl_pkg::CPU_W-1:0]    cpu_q;
  logic [pfl_pkg::ADDR_W-1:0]   addr_q;
  logic                         bad_q;
  logic [pfl_pkg::ALU_W-1:0]    base_q;
  logic [FW-1:0]                frame_q;
  logic [CW-1:0]                sel_q;

  logic [pfl_pkg::ADDR_W-1:0]   rslt_page_q;
  logic [pfl_pkg::STATUS_W-1:0] rslt_status_q;
  logic [pfl_pkg::CPU_W-1:0]    rslt_served_q;

  logic                         ov_q;
  logic [pfl_pkg::ADDR_W-1:0]   out_page_q;
  logic [pfl_pkg::STATUS_W-1:0] out_status_q;
  logic [pfl_pkg::CPU_W-1:0]    out_served_q;

  pfl_pkg::alu_op_t             alu_op;
  logic [pfl_pkg::ALU_W:0]      alu_res;

  logic                         mem_we, mem_re;
  logic [FW-1:0]                mem_waddr, mem_raddr, mem_wdata, mem_rdata;

  logic                         req_acc, out_load;
  logic                         own_ok, found;
  logic [CW-1:0]                pick_idx;
  logic [FFULL_W-1:0]           frame_full;

  pfl_alu u_alu (
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  pfl_ram #(
    .WIDTH (FW),
    .DEPTH (PAGES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign req_i.ready = (state_q == pfl_pkg::ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  assign rsp_o.valid       = ov_q;
  assign rsp_o.page_addr   = out_page_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.served_from = out_served_q;

  assign own_ok     = ({1'b0, cpu_q} < (pfl_pkg::CPU_W + 1)'(CPUS));
  assign frame_full = alu_res[pfl_pkg::ADDR_W-1:SHIFT];

  // list pick: own list first, else lowest non-empty list
  always_comb begin
    found    = 1'b0;
    pick_idx = '0;
    for (int i = CPUS - 1; i >= 0; i--) begin
      if (cnt_q[i] != 32'd0) begin
        found    = 1'b1;
        pick_idx = CW'(i);
      end
    end
    if (own_ok && (cnt_q[cpu_q[CW-1:0]] != 32'd0)) begin
      found    = 1'b1;
      pick_idx = cpu_q[CW-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    alu_op    = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = frame_q;
    mem_wdata = head_q[cpu_q[CW-1:0]];
    mem_raddr = head_q[pick_idx];
    out_load  = 1'b0;
    case (state_q)
      pfl_pkg::ST_IDLE: begin
        if (req_acc) begin
          state_d = pfl_pkg::ST_BASE;
        end
      end
      pfl_pkg::ST_BASE: begin
        alu_op.a = {1'b0, low_q};
        alu_op.b = OFS_MASK;
        state_d  = (kind_q == pfl_pkg::KIND_FREE) ? pfl_pkg::ST_CHK_LO : pfl_pkg::ST_PICK;
      end
      pfl_pkg::ST_CHK_LO: begin
        alu_op.a   = {1'b0, addr_q};
        alu_op.b   = {1'b0, low_q};
        alu_op.sub = 1'b1;
        state_d    = pfl_pkg::ST_CHK_HI;
      end
      pfl_pkg::ST_CHK_HI: begin
        alu_op.a   = {1'b0, addr_q};
        alu_op.b   = {1'b0, high_q};
        alu_op.sub = 1'b1;
        state_d    = pfl_pkg::ST_CHK_BASE;
      end
      pfl_pkg::ST_CHK_BASE: begin
        alu_op.a   = {1'b0, addr_q};
        alu_op.b   = base_q;
        alu_op.sub = 1'b1;
        state_d    = pfl_pkg::ST_PUSH;
      end
      pfl_pkg::ST_PUSH: begin
        mem_we  = !bad_q;
        state_d = pfl_pkg::ST_RESULT;
      end
      pfl_pkg::ST_PICK: begin
        mem_re  = found;
        state_d = found ? pfl_pkg::ST_LINK : pfl_pkg::ST_RESULT;
      end
      pfl_pkg::ST_LINK: begin
        alu_op.a = base_q;
        alu_op.b = {{(pfl_pkg::ALU_W - FW){1'b0}}, head_q[sel_q]} << SHIFT;
        state_d  = pfl_pkg::ST_RESULT;
      end
      pfl_pkg::ST_RESULT: begin
        if (!ov_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = pfl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pfl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= 32'h8000_0000;
      high_q <= 32'h8800_0000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pfl_pkg::REG_LOW_ADDR:  low_q  <= cfg_wdata_i;
        pfl_pkg::REG_HIGH_ADDR: high_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // list heads and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CPUS; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else if ((state_q == pfl_pkg::ST_PUSH) && !bad_q) begin
      head_q[cpu_q[CW-1:0]] <= frame_q;
      if (cnt_q[cpu_q[CW-1:0]] != 32'hFFFF_FFFF) begin
        cnt_q[cpu_q[CW-1:0]] <= cnt_q[cpu_q[CW-1:0]] + 32'd1;
      end
    end else if (state_q == pfl_pkg::ST_LINK) begin
      head_q[sel_q] <= mem_rdata;
      cnt_q[sel_q]  <= cnt_q[sel_q] - 32'd1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      pfl_pkg::ST_IDLE: begin
        if (req_acc) begin
          kind_q <= req_i.kind;
          cpu_q  <= req_i.cpu;
          addr_q <= req_i.address;
          bad_q  <= (|req_i.address[SHIFT-1:0]) ||
                    ({1'b0, req_i.cpu} >= (pfl_pkg::CPU_W + 1)'(CPUS));
        end
      end
      pfl_pkg::ST_BASE: begin
        base_q <= alu_res[pfl_pkg::ALU_W-1:0] & ~OFS_MASK;
      end
      pfl_pkg::ST_CHK_LO: begin
        bad_q <= bad_q || alu_res[pfl_pkg::ALU_W];
      end
      pfl_pkg::ST_CHK_HI: begin
        bad_q <= bad_q || !alu_res[pfl_pkg::ALU_W];
      end
      pfl_pkg::ST_CHK_BASE: begin
        bad_q   <= bad_q || alu_res[pfl_pkg::ALU_W] ||
                   (32'(frame_full) >= 32'(PAGES));
        frame_q <= frame_full[FW-1:0];
      end
      pfl_pkg::ST_PUSH: begin
        rslt_page_q   <= '0;
        rslt_served_q <= '0;
        rslt_status_q <= bad_q ? pfl_pkg::STATUS_BAD : pfl_pkg::STATUS_DONE;
      end
      pfl_pkg::ST_PICK: begin
        sel_q         <= pick_idx;
        rslt_page_q   <= '0;
        rslt_served_q <= '0;
        rslt_status_q <= pfl_pkg::STATUS_EMPTY;
      end
      pfl_pkg::ST_LINK: begin
        rslt_page_q   <= alu_res[pfl_pkg::ADDR_W-1:0];
        rslt_served_q <= pfl_pkg::CPU_W'(sel_q);
        rslt_status_q <= pfl_pkg::STATUS_DONE;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_load) begin
      ov_q <= 1'b1;
    end else if (rsp_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_page_q   <= rslt_page_q;
      out_status_q <= rslt_status_q;
      out_served_q <= rslt_served_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pfl_pkg::ST_LINK |=> cnt_q[$past(sel_q)] == $past(cnt_q[sel_q]) - 32'd1)
    else $error("pop did not decrement list count");

  a_pick_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pfl_pkg::ST_LINK |-> cnt_q[sel_q] != 32'd0)
    else $error("pop from empty list");

  a_no_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != pfl_pkg::STATUS_DONE) |->
      rsp_o.page_addr == '0 && rsp_o.served_from == '0)
    else $error("failed beat carries a page");

  a_write_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> head_q[$past(cpu_q[CW-1:0])] == $past(frame_q))
    else $error("link written without head update");
`endif

endmodule

[tb/sv/tb_per_cpu_page_free_list_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_cpu_page_free_list_allocator
// Self-checking bench for the per-CPU page free list allocator.
// ----------------------------------------------------------------------------
// Free and alloc requests go in over the request channel. A local copy of the
// lists, the link store and the bounds predicts each reply, and replies are
// checked in order. Directed items cover address and range corners, double
// frees, stealing and empty lists. The bounds registers go through extreme
// settings, some of them with pages still listed. A long reply stall fills
// the block. Random traffic then runs under several bounds settings, with
// idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb_per_cpu_page_free_list_allocator;

  localparam int CPUS         = 8;
  localparam int PAGES        = 32768;
  localparam int PAGE_BYTES   = 4096;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [pfl_pkg::ADDR_W-1:0]   page_addr;
    logic [pfl_pkg::STATUS_W-1:0] status;
    logic [pfl_pkg::CPU_W-1:0]    served_from;
  } page_reply_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [pfl_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [pfl_pkg::ADDR_W-1:0]    cfg_wdata_i;

  pfl_req_if req_ch ();
  pfl_rsp_if rsp_ch ();

  per_cpu_page_free_list_allocator #(
    .CPUS      (CPUS),
    .PAGES     (PAGES),
    .PAGE_BYTES(PAGE_BYTES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  always #6 clk_i = ~clk_i;

  // allocator shadow state
  logic [pfl_pkg::ADDR_W-1:0] lo_bound;
  logic [pfl_pkg::ADDR_W-1:0] hi_bound;
  logic [15:0]                head_q [CPUS];
  int unsigned                depth_q [CPUS];
  logic [15:0]                link_mem [PAGES];

  page_reply_t replies_due[$];
  int          mismatches  = 0;
  bit          jitter_on   = 1'b1;
  int          hold_ticket = 0;

  function automatic logic [pfl_pkg::ADDR_W:0] frame_base();
    logic [pfl_pkg::ADDR_W:0] b;
    b = {1'b0, lo_bound} + 33'(PAGE_BYTES - 1);
    return b - (b % PAGE_BYTES);
  endfunction

  function automatic bit pop_page(input int c, output logic [pfl_pkg::ADDR_W-1:0] pa);
    logic [15:0]              f;
    logic [pfl_pkg::ADDR_W:0] full;
    pa = '0;
    if (depth_q[c] == 0) return 1'b0;
    f = 16'(head_q[c] % PAGES);
    head_q[c] = link_mem[f];
    depth_q[c]--;
    full = frame_base() + 33'(f) * PAGE_BYTES;
    pa = full[pfl_pkg::ADDR_W-1:0];
    return 1'b1;
  endfunction

  function automatic page_reply_t predict_page_op(input logic kind,
                                                  input logic [pfl_pkg::CPU_W-1:0] cpu,
                                                  input logic [pfl_pkg::ADDR_W-1:0] addr);
    page_reply_t                r;
    logic [pfl_pkg::ADDR_W:0]   base;
    logic [pfl_pkg::ADDR_W:0]   frame;
    logic [pfl_pkg::ADDR_W-1:0] pa;
    bit                         got;
    int                         i;
    r = '0;
    if (kind == pfl_pkg::KIND_FREE) begin
      base = frame_base();
      if (int'(cpu) >= CPUS || addr % PAGE_BYTES != 0 || addr < lo_bound ||
          addr >= hi_bound || {1'b0, addr} < base) begin
        r.status = pfl_pkg::STATUS_BAD;
      end else begin
        frame = ({1'b0, addr} - base) / PAGE_BYTES;
        if (frame >= PAGES) begin
          r.status = pfl_pkg::STATUS_BAD;
        end else begin
          link_mem[frame] = head_q[cpu];
          head_q[cpu] = frame[15:0];
          if (depth_q[cpu] != 32'hFFFF_FFFF) depth_q[cpu]++;
        end
      end
    end else begin
      got = 1'b0;
      if (int'(cpu) < CPUS && pop_page(cpu, pa)) begin
        got = 1'b1;
        r.served_from = cpu;
        r.page_addr = pa;
      end
      for (i = 0; i < CPUS && !got; i++) begin
        if (i != int'(cpu) && pop_page(i, pa)) begin
          got = 1'b1;
          r.served_from = pfl_pkg::CPU_W'(i);
          r.page_addr = pa;
        end
      end
      if (!got) r.status = pfl_pkg::STATUS_EMPTY;
    end
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int sel;
    if (!jitter_on) return 0;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 0;
    else if (sel < 9) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // aligned, at or above base, below high (random if high is not above base); a few land past the link store
  function automatic logic [pfl_pkg::ADDR_W-1:0] pick_good_addr();
    logic [pfl_pkg::ADDR_W:0] base;
    logic [pfl_pkg::ADDR_W:0] top;
    logic [pfl_pkg::ADDR_W:0] full;
    int unsigned              frames;
    base = frame_base();
    top = {1'b0, hi_bound};
    if (top <= base) return $urandom;
    frames = int'((top - base + 33'(PAGE_BYTES - 1)) / PAGE_BYTES);
    if (frames > PAGES + 2) frames = PAGES + 2;
    full = base + 33'($urandom_range(0, frames - 1)) * PAGE_BYTES;
    return full[pfl_pkg::ADDR_W-1:0];
  endfunction

  task automatic send_item(input logic kind, input logic [pfl_pkg::CPU_W-1:0] cpu,
                           input logic [pfl_pkg::ADDR_W-1:0] addr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.kind    <= kind;
    req_ch.cpu     <= cpu;
    req_ch.address <= addr;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    replies_due.push_back(predict_page_op(kind, cpu, addr));
  endtask

  task automatic settle_block();
    req_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_bounds(input logic [pfl_pkg::ADDR_W-1:0] lo,
                              input logic [pfl_pkg::ADDR_W-1:0] hi);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= pfl_pkg::REG_LOW_ADDR;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    lo_bound = lo;
    cfg_idx_i   <= pfl_pkg::REG_HIGH_ADDR;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    hi_bound = hi;
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed_lists();
    send_item(pfl_pkg::KIND_ALLOC, 3'd2, 32'h0000_0000);
    send_item(pfl_pkg::KIND_FREE,  3'd0, 32'h8000_0000);
    send_item(pfl_pkg::KIND_FREE,  3'd7, 32'h87FF_F000);
    send_item(pfl_pkg::KIND_FREE,  3'd1, 32'h8000_0800);
    send_item(pfl_pkg::KIND_FREE,  3'd1, 32'h7FFF_F000);
    send_item(pfl_pkg::KIND_FREE,  3'd1, 32'h8800_0000);
    send_item(pfl_pkg::KIND_FREE,  3'd1, 32'hFFFF_FFFF);
    send_item(pfl_pkg::KIND_FREE,  3'd3, 32'h8000_5000);
    send_item(pfl_pkg::KIND_FREE,  3'd3, 32'h8000_5000);
    send_item(pfl_pkg::KIND_ALLOC, 3'd3, 32'hFFFF_FFFF);
    send_item(pfl_pkg::KIND_ALLOC, 3'd3, 32'h0000_0000);
    send_item(pfl_pkg::KIND_ALLOC, 3'd5, 32'h0000_0000);
    send_item(pfl_pkg::KIND_ALLOC, 3'd0, 32'h0000_0000);
    send_item(pfl_pkg::KIND_ALLOC, 3'd7, 32'h0000_0000);
  endtask

  task automatic test_bound_registers();
    settle_block();
    write_bounds(32'h8000_0801, 32'hFFFF_FFFF);
    send_item(pfl_pkg::KIND_FREE, 3'd4, 32'h8000_0000);
    send_item(pfl_pkg::KIND_FREE, 3'd4, 32'h8000_1000);
    send_item(pfl_pkg::KIND_FREE, 3'd6, 32'h8800_0000);
    send_item(pfl_pkg::KIND_FREE, 3'd6, 32'h8800_1000);
    // pages stay listed across the next write, so rebuilt addresses wrap
    settle_block();
    write_bounds(32'hFFFF_F001, 32'hFFFF_FFFF);
    send_item(pfl_pkg::KIND_FREE,  3'd2, 32'hFFFF_F000);
    send_item(pfl_pkg::KIND_ALLOC, 3'd1, 32'h0000_0000);
    send_item(pfl_pkg::KIND_ALLOC, 3'd1, 32'h0000_0000);
    settle_block();
    write_bounds(32'h0000_0000, 32'h0000_0000);
    send_item(pfl_pkg::KIND_FREE, 3'd0, 32'h0000_0000);
    settle_block();
    write_bounds(32'h0000_0000, 32'hFFFF_FFFF);
    send_item(pfl_pkg::KIND_FREE,  3'd5, 32'h0000_0000);
    send_item(pfl_pkg::KIND_FREE,  3'd5, 32'h0800_0000);
    send_item(pfl_pkg::KIND_ALLOC, 3'd0, 32'h0000_0000);
  endtask

  task automatic test_full_backpressure();
    int n;
    settle_block();
    write_bounds(32'h8000_0000, 32'h8800_0000);
    jitter_on = 1'b0;
    hold_ticket++;
    for (n = 0; n < 24; n++) begin
      if (n % 3 == 2) send_item(pfl_pkg::KIND_ALLOC, 3'($urandom_range(0, 7)), $urandom);
      else send_item(pfl_pkg::KIND_FREE, 3'($urandom_range(0, 7)), pick_good_addr());
    end
    settle_block();
    jitter_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int items_per_phase);
    int                         phase;
    int                         n;
    int                         sel;
    logic [pfl_pkg::ADDR_W-1:0] lo;
    logic [pfl_pkg::CPU_W-1:0]  cpu;
    logic                       kind;
    for (phase = 0; phase < 4; phase++) begin
      settle_block();
      case (phase)
        0: write_bounds(32'h8000_0000, 32'h8800_0000);
        1: write_bounds(32'h0000_0FFF, 32'h0002_1000);
        2: begin
          lo = $urandom_range(0, 32'hE000_0000);
          write_bounds(lo, lo + $urandom_range(32'h0000_1000, 32'h0900_0000));
        end
        default: write_bounds(32'hFFFF_0000, 32'hFFFF_FFFF);
      endcase
      for (n = 0; n < items_per_phase; n++) begin
        if (n % 25 == 0) jitter_on = ($urandom_range(0, 3) != 0);
        cpu = 3'($urandom_range(0, 7));
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          send_item(pfl_pkg::KIND_FREE, cpu, pick_good_addr());
        end else if (sel < 82) begin
          send_item(pfl_pkg::KIND_ALLOC, cpu, $urandom);
        end else begin
          kind = ($urandom_range(0, 1) == 1) ? pfl_pkg::KIND_FREE : pfl_pkg::KIND_ALLOC;
          if (sel < 91) send_item(kind, cpu, $urandom);
          else send_item(kind, cpu, pick_good_addr() ^ (32'h1 << $urandom_range(0, 31)));
        end
      end
    end
    jitter_on = 1'b1;
  endtask

  // reply side: random stalls, plus one long hold on request
  initial begin : reply_sink
    int stall;
    int seen;
    stall = 0;
    seen = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_ticket != seen) begin
        seen = hold_ticket;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        stall--;
        rsp_ch.ready <= 1'b0;
      end else if (jitter_on && $urandom_range(0, 3) == 0) begin
        stall = pick_gap();
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : reply_check
    page_reply_t want;
    if (rst_ni === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected reply beat, expected none, actual addr %h status %0d cpu %0d",
                 $time, rsp_ch.page_addr, rsp_ch.status, rsp_ch.served_from);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        if (rsp_ch.page_addr !== want.page_addr) begin
          $display("%0t: page_addr mismatch, expected %h, actual %h",
                   $time, want.page_addr, rsp_ch.page_addr);
          mismatches++;
        end
        if (rsp_ch.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, rsp_ch.status);
          mismatches++;
        end
        if (rsp_ch.served_from !== want.served_from) begin
          $display("%0t: served_from mismatch, expected %0d, actual %0d",
                   $time, want.served_from, rsp_ch.served_from);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: timeout with %0d replies outstanding", $time, replies_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : main_seq
    int i;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = pfl_pkg::REG_LOW_ADDR;
    cfg_wdata_i    = '0;
    req_ch.valid   = 1'b0;
    req_ch.kind    = pfl_pkg::KIND_ALLOC;
    req_ch.cpu     = '0;
    req_ch.address = '0;
    lo_bound = 32'h8000_0000;
    hi_bound = 32'h8800_0000;
    for (i = 0; i < CPUS; i++) begin
      head_q[i]  = '0;
      depth_q[i] = 0;
    end
    for (i = 0; i < PAGES; i++) link_mem[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_lists();
    test_bound_registers();
    test_full_backpressure();
    test_random_traffic(100);

    settle_block();
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
